### sv/pit_pkg.sv
// Shared types, constants and helper functions for the interval timer core.
package pit_pkg;

	localparam int NUM_CH = 3;
	localparam int CH_W = 2;
	localparam int CNT_W = 17;

	typedef logic [CH_W-1:0] ch_idx_t;

	// Channel access kind as set by a control word.
	typedef enum logic [1:0] {
		ACC_LATCH = 2'd0,
		ACC_LSB   = 2'd1,
		ACC_MSB   = 2'd2,
		ACC_WORD  = 2'd3
	} access_kind_t;

	// Bus port codes.
	localparam logic [2:0] PORT_CTRL   = 3'd3;
	localparam logic [2:0] PORT_SYSCTL = 3'd4;

	// Count modes that matter to the channel 0 interrupt and to counting.
	localparam logic [2:0] MODE_INT_TC    = 3'd0;
	localparam logic [2:0] MODE_RATE      = 3'd2;
	localparam logic [2:0] MODE_SQUARE    = 3'd3;
	localparam logic [2:0] MODE_SW_STROBE = 3'd4;

	localparam logic [1:0] CW_READBACK = 2'b11;
	localparam ch_idx_t    CH_IRQ      = 2'd0;
	localparam ch_idx_t    CH_SPKR     = 2'd2;

	localparam logic [7:0] RD_NONE    = 8'hFF;
	localparam logic [7:0] SYSCTL_OUT = 8'h20;

	// A reload value of zero stands for a full 65536-tick period.
	function automatic logic [CNT_W-1:0] full_reload(input logic [15:0] rv);
		logic [CNT_W-1:0] r;
		r = (rv == 16'd0) ? 17'h10000 : {1'b0, rv};
		return r;
	endfunction

	function automatic logic [15:0] shown_count(input logic running, input logic gate,
		input logic [15:0] rv, input logic [CNT_W-1:0] cur);
		logic [15:0] r;
		r = (!running || !gate) ? rv : cur[15:0];
		return r;
	endfunction

endpackage

### sv/programmable_interval_timer_core.sv
// Three-channel interval timer core with bus access and system control port.
//
// Each transaction on the item channel is either a byte-wide bus access or one
// timer tick, and each gives exactly one result transaction (read byte and the
// channel 0 interrupt pulse). An accepted item is captured in an input register
// and, once the result register can take it, one pass of logic updates all timer
// state and loads the result register, so one item is taken every cycle as long
// as the result side keeps up. The only stall comes from the result register
// being full and held by result_stall.
module programmable_interval_timer_core
	import pit_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic       func,
	input  logic [2:0] port,
	input  logic       wr_en,
	input  logic [7:0] wdata,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] rdata,
	output logic       irq
);

	// Input stage.
	logic       vld_s1;
	logic       func_s1;
	logic [2:0] port_s1;
	logic       wr_s1;
	logic [7:0] wdata_s1;

	// Result stage.
	logic       vld_s2;
	logic [7:0] rdata_s2;
	logic       irq_s2;

	logic advance;
	logic take;

	// Timer state.
	access_kind_t     acc_q     [NUM_CH];
	logic [2:0]       mode_q    [NUM_CH];
	logic [15:0]      reload_q  [NUM_CH];
	logic [CNT_W-1:0] cur_q     [NUM_CH];
	logic             lopend_q  [NUM_CH];
	logic [7:0]       lohold_q  [NUM_CH];
	logic             rdhi_q    [NUM_CH];
	logic             lfull_q   [NUM_CH];
	logic [15:0]      lval_q    [NUM_CH];
	logic             lhi_q     [NUM_CH];
	logic             run_q     [NUM_CH];
	logic             gate2_q;
	logic [3:0]       sysctl_q;
	logic             irq_arm_q;
	logic             irq_per_q;
	logic [CNT_W-1:0] irq_period_q;
	logic [CNT_W-1:0] irq_cd_q;

	access_kind_t     acc_d     [NUM_CH];
	logic [2:0]       mode_d    [NUM_CH];
	logic [15:0]      reload_d  [NUM_CH];
	logic [CNT_W-1:0] cur_d     [NUM_CH];
	logic             lopend_d  [NUM_CH];
	logic [7:0]       lohold_d  [NUM_CH];
	logic             rdhi_d    [NUM_CH];
	logic             lfull_d   [NUM_CH];
	logic [15:0]      lval_d    [NUM_CH];
	logic             lhi_d     [NUM_CH];
	logic             run_d     [NUM_CH];
	logic             gate2_d;
	logic [3:0]       sysctl_d;
	logic             irq_arm_d;
	logic             irq_per_d;
	logic [CNT_W-1:0] irq_period_d;
	logic [CNT_W-1:0] irq_cd_d;
	logic [7:0]       rdata_d;
	logic             irq_d;

	logic [NUM_CH-1:0] gate_lvl;

	assign gate_lvl = {gate2_q, 1'b1, 1'b1};

	assign advance    = vld_s1 && (!vld_s2 || !result_stall);
	assign item_stall = vld_s1 && !advance;
	assign take       = item_valid && !item_stall;

	assign result_valid = vld_s2;
	assign rdata        = rdata_s2;
	assign irq          = irq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (take) begin
				vld_s1 <= 1'b1;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (advance) begin
				vld_s2 <= 1'b1;
			end else if (!result_stall) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			func_s1  <= func;
			port_s1  <= port;
			wr_s1    <= wr_en;
			wdata_s1 <= wdata;
		end
		if (advance) begin
			rdata_s2 <= rdata_d;
			irq_s2   <= irq_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CH; c++) begin
				acc_q[c]    <= ACC_LATCH;
				mode_q[c]   <= '0;
				reload_q[c] <= '0;
				cur_q[c]    <= '0;
				lopend_q[c] <= 1'b0;
				lohold_q[c] <= '0;
				rdhi_q[c]   <= 1'b0;
				lfull_q[c]  <= 1'b0;
				lval_q[c]   <= '0;
				lhi_q[c]    <= 1'b0;
				run_q[c]    <= 1'b0;
			end
			gate2_q      <= 1'b0;
			sysctl_q     <= '0;
			irq_arm_q    <= 1'b0;
			irq_per_q    <= 1'b0;
			irq_period_q <= '0;
			irq_cd_q     <= '0;
		end else if (advance) begin
			for (int c = 0; c < NUM_CH; c++) begin
				acc_q[c]    <= acc_d[c];
				mode_q[c]   <= mode_d[c];
				reload_q[c] <= reload_d[c];
				cur_q[c]    <= cur_d[c];
				lopend_q[c] <= lopend_d[c];
				lohold_q[c] <= lohold_d[c];
				rdhi_q[c]   <= rdhi_d[c];
				lfull_q[c]  <= lfull_d[c];
				lval_q[c]   <= lval_d[c];
				lhi_q[c]    <= lhi_d[c];
				run_q[c]    <= run_d[c];
			end
			gate2_q      <= gate2_d;
			sysctl_q     <= sysctl_d;
			irq_arm_q    <= irq_arm_d;
			irq_per_q    <= irq_per_d;
			irq_period_q <= irq_period_d;
			irq_cd_q     <= irq_cd_d;
		end
	end

	// One pass of state update for the item held in the input stage.
	always_comb begin
		ch_idx_t          sel;
		ch_idx_t          cw_sel;
		logic             reload_fire;
		logic             use_latch;
		logic             hi_flag;
		logic [15:0]      v;
		logic [CNT_W-1:0] cd;
		logic [CNT_W-1:0] full0;

		for (int c = 0; c < NUM_CH; c++) begin
			acc_d[c]    = acc_q[c];
			mode_d[c]   = mode_q[c];
			reload_d[c] = reload_q[c];
			cur_d[c]    = cur_q[c];
			lopend_d[c] = lopend_q[c];
			lohold_d[c] = lohold_q[c];
			rdhi_d[c]   = rdhi_q[c];
			lfull_d[c]  = lfull_q[c];
			lval_d[c]   = lval_q[c];
			lhi_d[c]    = lhi_q[c];
			run_d[c]    = run_q[c];
		end
		gate2_d      = gate2_q;
		sysctl_d     = sysctl_q;
		irq_arm_d    = irq_arm_q;
		irq_per_d    = irq_per_q;
		irq_period_d = irq_period_q;
		irq_cd_d     = irq_cd_q;
		rdata_d      = '0;
		irq_d        = 1'b0;

		sel         = port_s1[CH_W-1:0];
		cw_sel      = wdata_s1[7:6];
		reload_fire = 1'b0;
		use_latch   = lfull_q[sel];
		hi_flag     = use_latch ? lhi_q[sel] : rdhi_q[sel];
		v           = use_latch ? lval_q[sel]
			: shown_count(run_q[sel], gate_lvl[sel], reload_q[sel], cur_q[sel]);
		cd          = '0;
		full0       = '0;

		if (func_s1) begin
			for (int c = 0; c < NUM_CH; c++) begin
				if (run_q[c] && gate_lvl[c]) begin
					if (mode_q[c] == MODE_INT_TC) begin
						if (cur_q[c] != '0) begin
							cur_d[c] = cur_q[c] - 1'b1;
						end
					end else if (cur_q[c] <= 17'd1) begin
						cur_d[c] = full_reload(reload_q[c]);
					end else begin
						cur_d[c] = cur_q[c] - 1'b1;
					end
				end
			end
			if (irq_arm_q) begin
				cd = (irq_cd_q != '0) ? irq_cd_q - 1'b1 : irq_cd_q;
				irq_cd_d = cd;
				if (cd == '0) begin
					irq_d = 1'b1;
					if (irq_per_q) begin
						irq_cd_d = irq_period_q;
					end else begin
						irq_arm_d = 1'b0;
					end
				end
			end
		end else if (port_s1 < PORT_CTRL) begin
			if (wr_s1) begin
				unique case (acc_q[sel])
					ACC_LSB: begin
						reload_d[sel] = {reload_q[sel][15:8], wdata_s1};
						reload_fire   = 1'b1;
					end
					ACC_MSB: begin
						reload_d[sel] = {wdata_s1, reload_q[sel][7:0]};
						reload_fire   = 1'b1;
					end
					ACC_WORD: begin
						if (!lopend_q[sel]) begin
							lohold_d[sel] = wdata_s1;
							lopend_d[sel] = 1'b1;
						end else begin
							reload_d[sel] = {wdata_s1, lohold_q[sel]};
							lopend_d[sel] = 1'b0;
							reload_fire   = 1'b1;
						end
					end
					ACC_LATCH: begin
					end
				endcase
			end else begin
				unique case (acc_q[sel])
					ACC_LSB: begin
						rdata_d = v[7:0];
						if (use_latch) begin
							lfull_d[sel] = 1'b0;
						end
					end
					ACC_MSB: begin
						rdata_d = v[15:8];
						if (use_latch) begin
							lfull_d[sel] = 1'b0;
						end
					end
					ACC_WORD: begin
						rdata_d = hi_flag ? v[15:8] : v[7:0];
						if (use_latch) begin
							lhi_d[sel] = !hi_flag;
							if (hi_flag) begin
								lfull_d[sel] = 1'b0;
							end
						end else begin
							rdhi_d[sel] = !hi_flag;
						end
					end
					ACC_LATCH: begin
						rdata_d = RD_NONE;
					end
				endcase
			end
		end else if (port_s1 == PORT_CTRL) begin
			if (wr_s1) begin
				if (cw_sel == CW_READBACK) begin
					for (int c = 0; c < NUM_CH; c++) begin
						if (wdata_s1[c+1]) begin
							lval_d[c]  = shown_count(run_q[c], gate_lvl[c], reload_q[c],
								cur_q[c]);
							lfull_d[c] = 1'b1;
							lhi_d[c]   = 1'b0;
						end
					end
				end else if (wdata_s1[5:4] == ACC_LATCH) begin
					lval_d[cw_sel]  = shown_count(run_q[cw_sel], gate_lvl[cw_sel],
						reload_q[cw_sel], cur_q[cw_sel]);
					lfull_d[cw_sel] = 1'b1;
					lhi_d[cw_sel]   = 1'b0;
				end else begin
					acc_d[cw_sel]    = access_kind_t'(wdata_s1[5:4]);
					mode_d[cw_sel]   = wdata_s1[3:1];
					lopend_d[cw_sel] = 1'b0;
					lohold_d[cw_sel] = '0;
					rdhi_d[cw_sel]   = 1'b0;
					lfull_d[cw_sel]  = 1'b0;
					run_d[cw_sel]    = 1'b0;
				end
			end else begin
				rdata_d = RD_NONE;
			end
		end else if (port_s1 == PORT_SYSCTL) begin
			if (wr_s1) begin
				sysctl_d = wdata_s1[3:0];
				gate2_d  = wdata_s1[0];
				// Restart channel 2 from its reload value on a rising gate.
				if (wdata_s1[0] && !gate2_q && run_q[CH_SPKR]) begin
					cur_d[CH_SPKR] = full_reload(reload_q[CH_SPKR]);
				end
			end else begin
				rdata_d = {6'd0, sysctl_q[1:0]};
				if (mode_q[CH_SPKR] == MODE_INT_TC && run_q[CH_SPKR]
					&& shown_count(run_q[CH_SPKR], gate2_q, reload_q[CH_SPKR],
					cur_q[CH_SPKR]) == 16'd0) begin
					rdata_d = rdata_d | SYSCTL_OUT;
				end
			end
		end else if (!wr_s1) begin
			rdata_d = RD_NONE;
		end

		// A completed reload value starts the channel, and on channel 0 sets up the irq.
		if (reload_fire) begin
			cur_d[sel] = full_reload(reload_d[sel]);
			run_d[sel] = 1'b1;
			if (sel == CH_IRQ) begin
				full0 = full_reload(reload_d[CH_IRQ]);
				if (mode_q[CH_IRQ] == MODE_INT_TC || mode_q[CH_IRQ] == MODE_RATE
					|| mode_q[CH_IRQ] == MODE_SQUARE || mode_q[CH_IRQ] == MODE_SW_STROBE) begin
					irq_per_d    = (mode_q[CH_IRQ] == MODE_RATE)
						|| (mode_q[CH_IRQ] == MODE_SQUARE);
					irq_period_d = full0;
					irq_cd_d     = full0;
					irq_arm_d    = 1'b1;
				end else begin
					irq_arm_d = 1'b0;
				end
			end
		end
	end

endmodule

### sv/pit_checker.sv
// Port-level checks for the interval timer core, bound to its top level.
module pit_checker
	import pit_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_stall,
	input logic       func,
	input logic [2:0] port,
	input logic       wr_en,
	input logic [7:0] wdata,
	input logic       result_valid,
	input logic       result_stall,
	input logic [7:0] rdata,
	input logic       irq
);

	// A held result must not change until the transaction completes.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(rdata) && $stable(irq))
		else $error("result changed while stalled");

	// The input side only backs up when the result register is full and held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("item stalled without a held result");

	// An accepted item moves from the input register into the result register if not held.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) ##1 !result_stall |=> result_valid)
		else $error("accepted item produced no result");

	// An interrupt pulse comes only from a tick, which never carries read data.
	a_irq_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && irq |-> rdata == 8'd0)
		else $error("irq result carries read data");

endmodule

bind programmable_interval_timer_core pit_checker u_pit_checker (.*);

### bench/programmable_interval_timer_core_tb.sv
// Self-checking testbench for the three-channel interval timer core.
module programmable_interval_timer_core_tb;
	import pit_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam bit FUNC_BUS  = 1'b0;
	localparam bit FUNC_TICK = 1'b1;
	localparam bit DIR_READ  = 1'b0;
	localparam bit DIR_WRITE = 1'b1;

	localparam logic [2:0] PORT_CH0     = 3'd0;
	localparam logic [2:0] PORT_CH2     = 3'd2;
	localparam logic [2:0] PORT_SPARE_A = 3'd5;
	localparam logic [2:0] PORT_SPARE_B = 3'd7;

	localparam bit [16:0] FULL_SPAN   = 17'h10000;
	localparam int DIRECTED_N         = 25;
	localparam int RANDOM_PER_PHASE   = 633;
	localparam int HOLD_OFF_CYCLES    = 300;
	localparam int TAIL_CYCLES        = 8;
	localparam int CYCLE_LIMIT        = 400000;
	localparam int MAX_REPORTS        = 10;

	typedef struct packed {
		logic [7:0] rdata;
		logic       irq;
	} timer_result_t;

	typedef struct packed {
		bit       fn;
		bit [2:0] prt;
		bit       wr;
		bit [7:0] dat;
		bit       typed;
		bit [7:0] want_rd;
		bit       want_irq;
	} stim_row_t;

	function automatic bit [7:0] ctrl_word(bit [1:0] sel, bit [1:0] acc, bit [2:0] mode);
		return {sel, acc, mode, 1'b0};
	endfunction

	// Rows with typed = 0 take their expectation from the timer model below.
	localparam stim_row_t DIRECTED [DIRECTED_N] = '{
		'{FUNC_BUS,  PORT_CH0,     DIR_READ,  8'h00, 1'b1, RD_NONE, 1'b0},
		'{FUNC_BUS,  PORT_CH0,     DIR_WRITE, 8'h55, 1'b1, 8'h00,   1'b0},
		'{FUNC_BUS,  PORT_CTRL,    DIR_READ,  8'h00, 1'b1, RD_NONE, 1'b0},
		'{FUNC_BUS,  PORT_SYSCTL,  DIR_READ,  8'h00, 1'b1, 8'h00,   1'b0},
		'{FUNC_BUS,  PORT_SPARE_B, DIR_WRITE, 8'hFF, 1'b1, 8'h00,   1'b0},
		'{FUNC_BUS,  PORT_SPARE_A, DIR_READ,  8'h00, 1'b1, RD_NONE, 1'b0},
		'{FUNC_TICK, PORT_SPARE_B, DIR_WRITE, 8'hFF, 1'b1, 8'h00,   1'b0},
		'{FUNC_BUS,  PORT_CTRL,    DIR_WRITE, ctrl_word(2'd0, ACC_WORD, MODE_RATE),
			1'b1, 8'h00, 1'b0},
		'{FUNC_BUS,  PORT_CH0,     DIR_WRITE, 8'h03, 1'b1, 8'h00,   1'b0},
		'{FUNC_BUS,  PORT_CH0,     DIR_WRITE, 8'h00, 1'b1, 8'h00,   1'b0},
		'{FUNC_BUS,  PORT_CH0,     DIR_READ,  8'h00, 1'b0, 8'h00,   1'b0},
		'{FUNC_TICK, PORT_CH0,     DIR_READ,  8'h00, 1'b0, 8'h00,   1'b0},
		'{FUNC_TICK, PORT_CH0,     DIR_READ,  8'h00, 1'b0, 8'h00,   1'b0},
		'{FUNC_TICK, PORT_CH0,     DIR_READ,  8'h00, 1'b0, 8'h00,   1'b0},
		'{FUNC_BUS,  PORT_CTRL,    DIR_WRITE, ctrl_word(2'd0, ACC_LATCH, MODE_INT_TC),
			1'b1, 8'h00, 1'b0},
		'{FUNC_TICK, PORT_CH0,     DIR_READ,  8'h00, 1'b0, 8'h00,   1'b0},
		'{FUNC_BUS,  PORT_CH0,     DIR_READ,  8'h00, 1'b0, 8'h00,   1'b0},
		'{FUNC_BUS,  PORT_CH0,     DIR_READ,  8'h00, 1'b0, 8'h00,   1'b0},
		'{FUNC_BUS,  PORT_CTRL,    DIR_WRITE, ctrl_word(2'd2, ACC_WORD, MODE_INT_TC),
			1'b1, 8'h00, 1'b0},
		'{FUNC_BUS,  PORT_CH2,     DIR_WRITE, 8'h00, 1'b1, 8'h00,   1'b0},
		'{FUNC_BUS,  PORT_CH2,     DIR_WRITE, 8'h00, 1'b1, 8'h00,   1'b0},
		'{FUNC_BUS,  PORT_SYSCTL,  DIR_WRITE, 8'hFF, 1'b1, 8'h00,   1'b0},
		'{FUNC_BUS,  PORT_SYSCTL,  DIR_READ,  8'h00, 1'b0, 8'h00,   1'b0},
		'{FUNC_BUS,  PORT_CTRL,    DIR_WRITE, ctrl_word(CW_READBACK, ACC_LSB, 3'b111),
			1'b1, 8'h00, 1'b0},
		'{FUNC_BUS,  PORT_CH2,     DIR_READ,  8'h00, 1'b0, 8'h00,   1'b0}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       item_valid;
	logic       item_stall;
	logic       func;
	logic [2:0] port;
	logic       wr_en;
	logic [7:0] wdata;
	logic       result_valid;
	logic       result_stall;
	logic [7:0] rdata;
	logic       irq;

	programmable_interval_timer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.func         (func),
		.port         (port),
		.wr_en        (wr_en),
		.wdata        (wdata),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.rdata        (rdata),
		.irq          (irq)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Timer model state.
	access_kind_t ch_access [NUM_CH];
	bit [2:0]     ch_mode [NUM_CH];
	bit [15:0]    ch_reload [NUM_CH];
	bit [16:0]    ch_count [NUM_CH];
	bit           lo_pending [NUM_CH];
	bit [7:0]     lo_hold [NUM_CH];
	bit           read_hi [NUM_CH];
	bit           snap_full [NUM_CH];
	bit [15:0]    snap_value [NUM_CH];
	bit           snap_hi [NUM_CH];
	bit           gate [NUM_CH];
	bit           running [NUM_CH];
	bit [3:0]     sysctl;
	bit           irq_on;
	bit           irq_repeat;
	bit [16:0]    irq_span;
	bit [16:0]    irq_left;

	timer_result_t pending_results [$];

	int gap_pct = 0;
	int stall_pct = 0;
	int hold_request = 0;
	int items_sent = 0;
	int results_seen = 0;
	int irq_pulses = 0;
	int mismatches = 0;
	int cycle_count = 0;

	function automatic void timer_reset();
		for (int c = 0; c < NUM_CH; c++) begin
			ch_access[c] = ACC_LATCH;
			ch_mode[c] = MODE_INT_TC;
			ch_reload[c] = '0;
			ch_count[c] = '0;
			lo_pending[c] = 1'b0;
			lo_hold[c] = '0;
			read_hi[c] = 1'b0;
			snap_full[c] = 1'b0;
			snap_value[c] = '0;
			snap_hi[c] = 1'b0;
			running[c] = 1'b0;
			gate[c] = (c != int'(CH_SPKR));
		end
		sysctl = '0;
		irq_on = 1'b0;
		irq_repeat = 1'b0;
		irq_span = '0;
		irq_left = '0;
	endfunction

	function automatic bit [16:0] reload_span(int c);
		return (ch_reload[c] == 16'd0) ? FULL_SPAN : {1'b0, ch_reload[c]};
	endfunction

	function automatic bit [15:0] visible_count(int c);
		return (!running[c] || !gate[c]) ? ch_reload[c] : ch_count[c][15:0];
	endfunction

	function automatic void latch_count(int c);
		snap_value[c] = visible_count(c);
		snap_full[c] = 1'b1;
		snap_hi[c] = 1'b0;
	endfunction

	function automatic void finish_reload(int c);
		ch_count[c] = reload_span(c);
		running[c] = 1'b1;
		if (c == int'(CH_IRQ)) begin
			case (ch_mode[c])
				MODE_INT_TC, MODE_RATE, MODE_SQUARE, MODE_SW_STROBE: begin
					irq_repeat = (ch_mode[c] == MODE_RATE) || (ch_mode[c] == MODE_SQUARE);
					irq_span = reload_span(c);
					irq_left = irq_span;
					irq_on = 1'b1;
				end
				default: irq_on = 1'b0;
			endcase
		end
	endfunction

	function automatic void write_counter(int c, bit [7:0] b);
		case (ch_access[c])
			ACC_LSB: begin
				ch_reload[c] = {ch_reload[c][15:8], b};
				finish_reload(c);
			end
			ACC_MSB: begin
				ch_reload[c] = {b, ch_reload[c][7:0]};
				finish_reload(c);
			end
			ACC_WORD: begin
				if (!lo_pending[c]) begin
					lo_hold[c] = b;
					lo_pending[c] = 1'b1;
				end else begin
					ch_reload[c] = {b, lo_hold[c]};
					lo_pending[c] = 1'b0;
					finish_reload(c);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic bit [7:0] read_counter(int c);
		bit        from_snap;
		bit [15:0] v;
		bit [7:0]  out;
		from_snap = snap_full[c];
		v = from_snap ? snap_value[c] : visible_count(c);
		case (ch_access[c])
			ACC_LSB: begin
				out = v[7:0];
				if (from_snap)
					snap_full[c] = 1'b0;
			end
			ACC_MSB: begin
				out = v[15:8];
				if (from_snap)
					snap_full[c] = 1'b0;
			end
			ACC_WORD: begin
				// A latched value and the live count keep separate byte orders.
				if (from_snap) begin
					out = snap_hi[c] ? v[15:8] : v[7:0];
					if (snap_hi[c])
						snap_full[c] = 1'b0;
					snap_hi[c] = !snap_hi[c];
				end else begin
					out = read_hi[c] ? v[15:8] : v[7:0];
					read_hi[c] = !read_hi[c];
				end
			end
			default: out = RD_NONE;
		endcase
		return out;
	endfunction

	function automatic void write_control(bit [7:0] cw);
		int sel;
		sel = int'(cw[7:6]);
		if (cw[7:6] == CW_READBACK) begin
			for (int c = 0; c < NUM_CH; c++)
				if (cw[c+1])
					latch_count(c);
		end else if (cw[5:4] == ACC_LATCH) begin
			latch_count(sel);
		end else begin
			ch_access[sel] = access_kind_t'(cw[5:4]);
			ch_mode[sel] = cw[3:1];
			lo_pending[sel] = 1'b0;
			lo_hold[sel] = '0;
			read_hi[sel] = 1'b0;
			snap_full[sel] = 1'b0;
			running[sel] = 1'b0;
		end
	endfunction

	function automatic void write_sysctl(bit [7:0] b);
		int c;
		c = int'(CH_SPKR);
		sysctl = b[3:0];
		if (b[0] != gate[c]) begin
			gate[c] = b[0];
			if (b[0] && running[c])
				ch_count[c] = reload_span(c);
		end
	endfunction

	function automatic bit [7:0] read_sysctl();
		bit [7:0] v;
		int       c;
		c = int'(CH_SPKR);
		v = {6'd0, sysctl[1:0]};
		if (ch_mode[c] == MODE_INT_TC && running[c] && visible_count(c) == 16'd0)
			v = v | SYSCTL_OUT;
		return v;
	endfunction

	function automatic bit tick_timers();
		bit fire;
		fire = 1'b0;
		for (int c = 0; c < NUM_CH; c++) begin
			if (running[c] && gate[c]) begin
				if (ch_mode[c] == MODE_INT_TC) begin
					if (ch_count[c] != 17'd0)
						ch_count[c] = ch_count[c] - 17'd1;
				end else if (ch_count[c] <= 17'd1) begin
					ch_count[c] = reload_span(c);
				end else begin
					ch_count[c] = ch_count[c] - 17'd1;
				end
			end
		end
		if (irq_on) begin
			if (irq_left != 17'd0)
				irq_left = irq_left - 17'd1;
			if (irq_left == 17'd0) begin
				fire = 1'b1;
				if (irq_repeat)
					irq_left = irq_span;
				else
					irq_on = 1'b0;
			end
		end
		return fire;
	endfunction

	function automatic timer_result_t timer_step(bit fn, bit [2:0] prt, bit wr, bit [7:0] dat);
		timer_result_t r;
		r = '{rdata: 8'h00, irq: 1'b0};
		if (fn == FUNC_TICK) begin
			r.irq = tick_timers();
		end else if (prt < PORT_CTRL) begin
			if (wr)
				write_counter(int'(prt), dat);
			else
				r.rdata = read_counter(int'(prt));
		end else if (prt == PORT_CTRL) begin
			if (wr)
				write_control(dat);
			else
				r.rdata = RD_NONE;
		end else if (prt == PORT_SYSCTL) begin
			if (wr)
				write_sysctl(dat);
			else
				r.rdata = read_sysctl();
		end else if (!wr) begin
			r.rdata = RD_NONE;
		end
		return r;
	endfunction

	task automatic offer(input bit fn, input bit [2:0] prt, input bit wr, input bit [7:0] dat,
		input bit typed = 1'b0, input bit [7:0] want_rd = 8'h00, input bit want_irq = 1'b0);
		timer_result_t res;
		while ($urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		func <= fn;
		port <= prt;
		wr_en <= wr;
		wdata <= dat;
		do
			@(posedge clk);
		while (item_stall !== 1'b0);
		res = timer_step(fn, prt, wr, dat);
		if (typed)
			res = '{rdata: want_rd, irq: want_irq};
		pending_results.push_back(res);
		items_sent++;
	endtask

	task automatic bus_write(input bit [2:0] prt, input bit [7:0] dat);
		offer(FUNC_BUS, prt, DIR_WRITE, dat);
	endtask

	task automatic bus_read(input bit [2:0] prt);
		offer(FUNC_BUS, prt, DIR_READ, 8'($urandom));
	endtask

	task automatic timer_tick();
		offer(FUNC_TICK, 3'($urandom_range(7)), 1'($urandom), 8'($urandom));
	endtask

	// Mostly well-formed programming, counting and readout, with some noise mixed in.
	task automatic random_burst();
		int           pick;
		int           sel;
		access_kind_t acc;
		bit [2:0]     mode;
		bit [15:0]    rv;
		pick = $urandom_range(99);
		sel = $urandom_range(2);
		if (pick < 30) begin
			acc = access_kind_t'($urandom_range(1, 3));
			if ($urandom_range(1) == 0) begin
				mode = 3'($urandom_range(7));
			end else begin
				case ($urandom_range(3))
					0: mode = MODE_INT_TC;
					1: mode = MODE_RATE;
					2: mode = MODE_SQUARE;
					default: mode = MODE_SW_STROBE;
				endcase
			end
			rv = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(24));
			bus_write(PORT_CTRL, ctrl_word(2'(sel), acc, mode));
			case (acc)
				ACC_LSB: bus_write(3'(sel), rv[7:0]);
				ACC_MSB: bus_write(3'(sel), 8'($urandom_range(3)));
				default: begin
					bus_write(3'(sel), rv[7:0]);
					if ($urandom_range(9) == 0)
						bus_read(3'(sel));
					// Now and then the high byte never comes.
					if ($urandom_range(9) != 0)
						bus_write(3'(sel), rv[15:8]);
				end
			endcase
			if (sel == int'(CH_SPKR) && $urandom_range(1) == 0)
				bus_write(PORT_SYSCTL, 8'($urandom) | 8'h01);
		end else if (pick < 65) begin
			repeat ($urandom_range(1, 30))
				timer_tick();
		end else if (pick < 80) begin
			case ($urandom_range(2))
				0: bus_write(PORT_CTRL, ctrl_word(2'(sel), ACC_LATCH, 3'($urandom)));
				1: bus_write(PORT_CTRL, ctrl_word(CW_READBACK, 2'($urandom), 3'($urandom)));
				default: ;
			endcase
			repeat ($urandom_range(1, 3))
				bus_read(3'(sel));
		end else if (pick < 90) begin
			bus_write(PORT_SYSCTL, 8'($urandom));
			bus_read(PORT_SYSCTL);
		end else begin
			offer(1'($urandom), 3'($urandom_range(7)), 1'($urandom), 8'($urandom));
		end
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic note_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("MISMATCH %s: expected %02h, got %02h (result %0d)", what, want, got,
				results_seen);
	endtask

	always @(posedge clk) begin : result_check
		timer_result_t want;
		if (result_valid === 1'b1 && result_stall == 1'b0) begin
			if (pending_results.size() == 0) begin
				note_mismatch("result with nothing pending", 8'h00, rdata);
			end else begin
				want = pending_results.pop_front();
				if (rdata !== want.rdata)
					note_mismatch("rdata", want.rdata, rdata);
				if (irq !== want.irq)
					note_mismatch("irq", {7'd0, want.irq}, {7'd0, irq});
				if (want.irq)
					irq_pulses++;
			end
			results_seen++;
		end
	end

	// Result side; a hold-off request is counted out here, cycle by cycle.
	initial begin : result_side
		int hold_left;
		hold_left = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run exceeded %0d cycles with %0d results outstanding.", CYCLE_LIMIT,
			pending_results.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		func <= FUNC_BUS;
		port <= PORT_CH0;
		wr_en <= DIR_READ;
		wdata <= 8'h00;
		timer_reset();
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;

		gap_pct = 7;
		stall_pct = 49;
		for (int i = 0; i < DIRECTED_N; i++)
			offer(DIRECTED[i].fn, DIRECTED[i].prt, DIRECTED[i].wr, DIRECTED[i].dat,
				DIRECTED[i].typed, DIRECTED[i].want_rd, DIRECTED[i].want_irq);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin gap_pct = 7; stall_pct = 49; end
				1: begin gap_pct = 49; stall_pct = 7; end
				default: begin
					gap_pct = 0;
					stall_pct = 0;
					// Results are held back while items keep coming, so the core backs up.
					hold_request = HOLD_OFF_CYCLES;
				end
			endcase
			while (items_sent < DIRECTED_N + RANDOM_PER_PHASE * (phase + 1))
				random_burst();
			drain_results();
		end

		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (pending_results.size() != 0)
			note_mismatch("results never delivered", 8'(pending_results.size()), 8'h00);

		$display("Sent %0d transactions (%0d directed), checked %0d results, %0d irq pulses.",
			items_sent, DIRECTED_N, results_seen, irq_pulses);
		$display("Idle mixes: sender-heavy, receiver-heavy, none; one long result hold-off.");
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches in total.", mismatches);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
sv/pit_pkg.sv
sv/programmable_interval_timer_core.sv
sv/pit_checker.sv
bench/programmable_interval_timer_core_tb.sv
